FILE: sv/ale_pkg.sv
// Shared types and constants for the array list engine.
// Holds the word structs, command and status codes and the
// controller-to-datapath command and status bundles. Depends on nothing.
package ale_pkg;

  // Default sizing handed to the top level
  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 16;

  // Fixed field widths of the channel words
  localparam int CMD_W   = 4;
  localparam int POS_W   = 7;
  localparam int IDF_W   = 16;
  localparam int STAT_W  = 2;
  localparam int MIDX_W  = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    OP_GET       = 4'd0,
    OP_SET       = 4'd1,
    OP_INS_FRONT = 4'd2,
    OP_INS_BACK  = 4'd3,
    OP_INS_AT    = 4'd4,
    OP_REM_FRONT = 4'd5,
    OP_REM_BACK  = 4'd6,
    OP_REM_AT    = 4'd7,
    OP_FIND      = 4'd8,
    OP_INDEX_OF  = 4'd9,
    OP_CLEAR     = 4'd10
  } ale_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } ale_status_t;

  // Where a pointer load takes its value from
  typedef enum logic [1:0] {
    PS_ZERO  = 2'd0,
    PS_COUNT = 2'd1,
    PS_POSM1 = 2'd2,
    PS_CNTM1 = 2'd3
  } ale_psel_t;

  // Read address relative to the walk pointer
  typedef enum logic [1:0] {
    RD_PTR   = 2'd0,
    RD_BELOW = 2'd1,
    RD_ABOVE = 2'd2
  } ale_rsel_t;

  // Walk pointer motion
  typedef enum logic [1:0] {
    MV_HOLD = 2'd0,
    MV_INC  = 2'd1,
    MV_DEC  = 2'd2
  } ale_mv_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [IDF_W-1:0] item_id;
  } ale_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDF_W-1:0]   result_id;
    logic               found;
    logic [MIDX_W-1:0]  match_index;
    logic [COUNT_W-1:0] entry_count;
  } ale_out_t;

  // Controller to datapath
  typedef struct packed {
    logic        load;
    logic        ld_ptr;
    ale_psel_t   ptr_sel;
    logic        ld_k;
    ale_psel_t   k_sel;
    logic        rd_en;
    ale_rsel_t   rd_sel;
    ale_mv_t     mv;
    logic        shift;
    logic        scan;
    logic        place;
    logic        cap_rid;
    logic        cap_hit;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        cnt_clr;
    logic        err_en;
    ale_status_t err_code;
    logic        emit;
  } ale_cmd_t;

  // Datapath to controller
  typedef struct packed {
    ale_op_t op;
    logic    full;
    logic    empty;
    logic    pos_ok;
    logic    ptr_above_k;
    logic    ptr_nxt_in;
    logic    ptr_in;
    logic    pend;
    logic    cmp_v;
    logic    found;
    logic    out_free;
  } ale_sts_t;

endpackage

FILE: sv/ale_dp.sv
// Datapath of the array list engine: entry memory, count, walk pointer,
// shift and compare pipeline, result registers and output word register.
// Depends on ale_pkg; driven by ale_ctrl through ale_cmd_t.
module ale_dp #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = ale_pkg::ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ale_pkg::ale_in_t in_data,
  input  ale_pkg::ale_cmd_t cmd,
  output ale_pkg::ale_sts_t sts,
  output logic             out_valid,
  input  logic             out_stall,
  output ale_pkg::ale_out_t out_data
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Latched command word
  ale_pkg::ale_op_t op_r;
  logic [ale_pkg::POS_W-1:0] pos_r;
  logic [ID_BITS-1:0] id_r;
  logic [31:0] id_ext;

  // Control state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] k_r;
  logic [AW-1:0]    dst_r;
  logic             pend_r, pend_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]    cmp_idx_r;
  logic             out_valid_r, out_valid_nxt;

  // Memory and results
  logic [ID_BITS-1:0] mem [CAPACITY];
  logic [ID_BITS-1:0] rdata_r;
  ale_pkg::ale_status_t st_r;
  logic [ID_BITS-1:0] rid_r;
  logic               found_r;
  logic [AW-1:0]      midx_r;
  ale_pkg::ale_out_t  out_r;

  logic [CNT_W-1:0] posm1, cntm1, ptr_val, k_val, rd_ptr;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  logic [ID_BITS-1:0] wr_data;
  logic             hit;
  logic [31:0]      rid_ext, midx_ext, cnt_ext;

  assign id_ext = 32'(in_data.item_id);
  assign posm1  = CNT_W'(32'(pos_r) - 32'd1);
  assign cntm1  = count_r - CNT_W'(1);

  function automatic logic [CNT_W-1:0] pick(input ale_pkg::ale_psel_t sel,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic [CNT_W-1:0] pm1,
                                            input logic [CNT_W-1:0] cm1);
    logic [CNT_W-1:0] v;
    unique case (sel)
      ale_pkg::PS_ZERO:  v = '0;
      ale_pkg::PS_COUNT: v = cnt;
      ale_pkg::PS_POSM1: v = pm1;
      ale_pkg::PS_CNTM1: v = cm1;
      default:           v = '0;
    endcase
    return v;
  endfunction

  assign ptr_val = pick(cmd.ptr_sel, count_r, posm1, cntm1);
  assign k_val   = pick(cmd.k_sel, count_r, posm1, cntm1);

  // Status back to the controller
  always_comb begin
    sts.op          = op_r;
    sts.full        = count_r >= CNT_W'(CAPACITY);
    sts.empty       = count_r == '0;
    sts.pos_ok      = (pos_r != '0) && (32'(pos_r) <= 32'(count_r));
    sts.ptr_above_k = ptr_r > k_r;
    sts.ptr_nxt_in  = ({1'b0, ptr_r} + (CNT_W+1)'(1)) < {1'b0, count_r};
    sts.ptr_in      = ptr_r < count_r;
    sts.pend        = pend_r;
    sts.cmp_v       = cmp_v_r;
    sts.found       = found_r;
    sts.out_free    = !out_valid_r || !out_stall;
  end

  // Read address relative to the walk pointer
  always_comb begin
    unique case (cmd.rd_sel)
      ale_pkg::RD_BELOW: rd_ptr = ptr_r - CNT_W'(1);
      ale_pkg::RD_ABOVE: rd_ptr = ptr_r + CNT_W'(1);
      default:           rd_ptr = ptr_r;
    endcase
  end
  assign rd_addr = rd_ptr[AW-1:0];

  // Pending shift write wins the port; a place writes the new id
  assign wr_en   = pend_r || cmd.place;
  assign wr_addr = pend_r ? dst_r : ptr_r[AW-1:0];
  assign wr_data = pend_r ? rdata_r : id_r;

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Next values of the control state
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end

    ptr_nxt = ptr_r;
    if (cmd.ld_ptr) begin
      ptr_nxt = ptr_val;
    end else begin
      unique case (cmd.mv)
        ale_pkg::MV_INC: ptr_nxt = ptr_r + CNT_W'(1);
        ale_pkg::MV_DEC: ptr_nxt = ptr_r - CNT_W'(1);
        default:         ptr_nxt = ptr_r;
      endcase
    end

    pend_nxt  = cmd.shift;
    cmp_v_nxt = cmd.scan;

    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk pointer, bound and pipeline tags
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.ld_k) begin
      k_r <= k_val;
    end
    if (cmd.shift) begin
      dst_r <= ptr_r[AW-1:0];
    end
    if (cmd.scan) begin
      cmp_idx_r <= ptr_r[AW-1:0];
    end
  end

  assign hit = cmp_v_r && (rdata_r == id_r);

  // Latch the command word and clear the results on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= ale_pkg::ale_op_t'(in_data.command);
      pos_r   <= in_data.position;
      id_r    <= id_ext[ID_BITS-1:0];
      st_r    <= ale_pkg::ST_OK;
      rid_r   <= '0;
      found_r <= 1'b0;
      midx_r  <= '0;
    end else begin
      if (cmd.err_en) begin
        st_r <= cmd.err_code;
      end
      if (cmd.cap_rid) begin
        rid_r <= rdata_r;
      end
      if (cmd.cap_hit && hit) begin
        if (op_r == ale_pkg::OP_FIND && !found_r) begin
          found_r <= 1'b1;
          rid_r   <= rdata_r;
        end else if (op_r == ale_pkg::OP_INDEX_OF) begin
          found_r <= 1'b1;
          midx_r  <= cmp_idx_r;
        end
      end
    end
  end

  // Output word register
  assign rid_ext  = 32'(rid_r);
  assign midx_ext = 32'(midx_r);
  assign cnt_ext  = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status      <= st_r;
      out_r.result_id   <= rid_ext[ale_pkg::IDF_W-1:0];
      out_r.found       <= found_r;
      out_r.match_index <= midx_ext[ale_pkg::MIDX_W-1:0];
      out_r.entry_count <= cnt_ext[ale_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_place_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> !pend_r) else $error("place collides with shift write");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY)) else $error("count above capacity");
  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (count_r < CNT_W'(CAPACITY))) else $error("insert into full list");
  a_pend_from_shift: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(cmd.shift)) else $error("shift write without read");
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r) else $error("emitted word not shown");

endmodule

FILE: sv/ale_ctrl.sv
// Controller of the array list engine: decodes the latched command,
// checks errors and steps the datapath through reads, shifts and scans.
// Depends on ale_pkg; talks to ale_dp only through ale_cmd_t / ale_sts_t.
module ale_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ale_pkg::ale_sts_t sts,
  output ale_pkg::ale_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_TAKE   = 8'b0000_1000,
    S_SHUP   = 8'b0001_0000,
    S_SHDN   = 8'b0010_0000,
    S_SCAN   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   scan_stop;

  assign in_stall  = state_r != S_IDLE;
  assign scan_stop = (!sts.ptr_in && !sts.cmp_v) ||
                     (sts.op == ale_pkg::OP_FIND && sts.found);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.ptr_sel  = ale_pkg::PS_ZERO;
    cmd.k_sel    = ale_pkg::PS_ZERO;
    cmd.rd_sel   = ale_pkg::RD_PTR;
    cmd.mv       = ale_pkg::MV_HOLD;
    cmd.err_code = ale_pkg::ST_OK;

    unique case (state_r)
      // Take a word
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end

      // Check errors in order and set up the walk
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (sts.op)
          ale_pkg::OP_GET, ale_pkg::OP_REM_AT: begin
            if (!sts.pos_ok) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = ale_pkg::ST_BADPOS;
            end else begin
              cmd.ld_ptr  = 1'b1;
              cmd.ptr_sel = ale_pkg::PS_POSM1;
              state_nxt   = S_READ;
            end
          end
          ale_pkg::OP_SET: begin
            if (!sts.pos_ok) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = ale_pkg::ST_BADPOS;
            end else begin
              cmd.ld_ptr  = 1'b1;
              cmd.ptr_sel = ale_pkg::PS_POSM1;
              cmd.ld_k    = 1'b1;
              cmd.k_sel   = ale_pkg::PS_POSM1;
              state_nxt   = S_SHUP;
            end
          end
          ale_pkg::OP_INS_FRONT, ale_pkg::OP_INS_BACK, ale_pkg::OP_INS_AT: begin
            priority if (sts.full) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = ale_pkg::ST_FULL;
            end else if (sts.op == ale_pkg::OP_INS_AT && !sts.pos_ok) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = ale_pkg::ST_BADPOS;
            end else begin
              cmd.ld_ptr  = 1'b1;
              cmd.ptr_sel = ale_pkg::PS_COUNT;
              cmd.ld_k    = 1'b1;
              if (sts.op == ale_pkg::OP_INS_FRONT) begin
                cmd.k_sel = ale_pkg::PS_ZERO;
              end else if (sts.op == ale_pkg::OP_INS_BACK) begin
                cmd.k_sel = ale_pkg::PS_COUNT;
              end else begin
                cmd.k_sel = ale_pkg::PS_POSM1;
              end
              state_nxt = S_SHUP;
            end
          end
          ale_pkg::OP_REM_FRONT, ale_pkg::OP_REM_BACK: begin
            if (sts.empty) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = ale_pkg::ST_EMPTY;
            end else begin
              cmd.ld_ptr  = 1'b1;
              cmd.ptr_sel = (sts.op == ale_pkg::OP_REM_FRONT) ? ale_pkg::PS_ZERO
                                                              : ale_pkg::PS_CNTM1;
              state_nxt   = S_READ;
            end
          end
          ale_pkg::OP_FIND, ale_pkg::OP_INDEX_OF: begin
            if (sts.empty) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = ale_pkg::ST_EMPTY;
            end else begin
              cmd.ld_ptr  = 1'b1;
              cmd.ptr_sel = ale_pkg::PS_ZERO;
              state_nxt   = S_SCAN;
            end
          end
          ale_pkg::OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // Read the addressed entry
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_TAKE;
      end

      // Capture it; removals go on to close the gap
      S_TAKE: begin
        cmd.cap_rid = 1'b1;
        state_nxt   = (sts.op == ale_pkg::OP_GET) ? S_DONE : S_SHDN;
      end

      // Move entries up one place, then drop the new id in the hole
      S_SHUP: begin
        if (sts.ptr_above_k) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ale_pkg::RD_BELOW;
          cmd.mv     = ale_pkg::MV_DEC;
          cmd.shift  = 1'b1;
        end else if (!sts.pend) begin
          cmd.place   = 1'b1;
          cmd.cnt_inc = sts.op != ale_pkg::OP_SET;
          state_nxt   = S_DONE;
        end
      end

      // Move entries down one place over the removed one
      S_SHDN: begin
        if (sts.ptr_nxt_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ale_pkg::RD_ABOVE;
          cmd.mv     = ale_pkg::MV_INC;
          cmd.shift  = 1'b1;
        end else if (!sts.pend) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end

      // Walk the entries and compare one per cycle
      S_SCAN: begin
        cmd.cap_hit = 1'b1;
        if (scan_stop) begin
          state_nxt = S_DONE;
        end else if (sts.ptr_in) begin
          cmd.rd_en = 1'b1;
          cmd.mv    = ale_pkg::MV_INC;
          cmd.scan  = 1'b1;
        end
      end

      // Hand the result word to the output register
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DECODE) else $error("accepted word not decoded");
  a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> (state_r == S_SHUP || state_r == S_SHDN)) else $error("stray shift");
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !in_stall) else $error("no return to idle after emit");

endmodule

FILE: sv/array_list_engine.sv
// Top level of the array list engine: ordered list of ids in a memory.
// Joins ale_ctrl (sequencer) and ale_dp (memory, count, results).
// Depends on ale_pkg.
//
//   channel  ports                        direction  word
//   in       in_valid, in_stall, in_data  to block   ale_in_t  (command, position, item_id)
//   out      out_valid, out_stall, out_data from block ale_out_t (status .. entry_count)
//
// One word at a time: no new word is taken until the result of the last one has
// gone to the output register. Inserts and removals shift the entries behind
// the position, and find and index_of compare entries from the front. The entry
// memory moves or compares one entry per cycle.
// Reset (rst_n low, synchronous) empties the list; memory contents are kept.
// A stalled result sits in the output register while the next word is taken;
// that word then waits in its last cycle until the output register frees up.
module array_list_engine #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = ale_pkg::ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ale_pkg::ale_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ale_pkg::ale_out_t out_data
);

  ale_pkg::ale_cmd_t cmd;
  ale_pkg::ale_sts_t sts;

  ale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ale_dp #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: bench/tb_array_list_engine.sv
// Testbench for array_list_engine: directed and random list commands, with a
// scoreboard class that predicts each result word. Depends on ale_pkg and the RTL.
`timescale 1ns / 1ps

module tb_array_list_engine;

  localparam int          LIST_DEPTH   = ale_pkg::CAPACITY_DEF;
  localparam int          RANDOM_WORDS = 800;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          TAIL_CYCLES  = LIST_DEPTH + 20;
  localparam longint      RUN_LIMIT_NS = 64'd10_000_000;
  localparam logic [3:0]  FIRST_UNUSED_OP = 4'd11;
  localparam logic [3:0]  LAST_UNUSED_OP  = 4'd15;

  typedef enum int {MIX_BALANCED, MIX_GROW, MIX_SHRINK} mix_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_PERIODIC} stall_style_t;

  // Predicts result words from accepted command words and checks them in order
  class list_scoreboard;
    logic [ale_pkg::IDF_W-1:0] slots [LIST_DEPTH];
    int unsigned               used;
    ale_pkg::ale_out_t         pending_q [$];
    int unsigned               mismatches;
    int unsigned               words_in;
    int unsigned               words_out;
    int unsigned               peak_fill;
    int unsigned               search_hits;
    int unsigned               status_tally [4];

    function new();
      used = 0;
      mismatches = 0;
      words_in = 0;
      words_out = 0;
      peak_fill = 0;
      search_hits = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function bit pos_valid(int unsigned p);
      return p >= 1 && p <= used;
    endfunction

    // Open a hole at k by moving the used tail up one slot
    function void put_slot(int unsigned k, logic [ale_pkg::IDF_W-1:0] v);
      for (int unsigned i = used; i > k; i--) slots[i] = slots[i-1];
      slots[k] = v;
      used++;
    endfunction

    // Close the hole at k by moving the used tail down one slot
    function logic [ale_pkg::IDF_W-1:0] take_slot(int unsigned k);
      logic [ale_pkg::IDF_W-1:0] v;
      v = slots[k];
      for (int unsigned i = k; i + 1 < used; i++) slots[i] = slots[i+1];
      used--;
      return v;
    endfunction

    function void note_word(ale_pkg::ale_in_t w);
      ale_pkg::ale_out_t r;
      int unsigned       p;
      r = '0;
      p = w.position;
      case (w.command)
        ale_pkg::OP_GET: begin
          if (!pos_valid(p)) r.status = ale_pkg::ST_BADPOS;
          else r.result_id = slots[p-1];
        end
        ale_pkg::OP_SET: begin
          if (!pos_valid(p)) r.status = ale_pkg::ST_BADPOS;
          else slots[p-1] = w.item_id;
        end
        ale_pkg::OP_INS_FRONT: begin
          if (used >= LIST_DEPTH) r.status = ale_pkg::ST_FULL;
          else put_slot(0, w.item_id);
        end
        ale_pkg::OP_INS_BACK: begin
          if (used >= LIST_DEPTH) r.status = ale_pkg::ST_FULL;
          else put_slot(used, w.item_id);
        end
        ale_pkg::OP_INS_AT: begin
          if (used >= LIST_DEPTH) r.status = ale_pkg::ST_FULL;
          else if (!pos_valid(p)) r.status = ale_pkg::ST_BADPOS;
          else put_slot(p - 1, w.item_id);
        end
        ale_pkg::OP_REM_FRONT: begin
          if (used == 0) r.status = ale_pkg::ST_EMPTY;
          else r.result_id = take_slot(0);
        end
        ale_pkg::OP_REM_BACK: begin
          if (used == 0) r.status = ale_pkg::ST_EMPTY;
          else r.result_id = take_slot(used - 1);
        end
        ale_pkg::OP_REM_AT: begin
          if (!pos_valid(p)) r.status = ale_pkg::ST_BADPOS;
          else r.result_id = take_slot(p - 1);
        end
        ale_pkg::OP_FIND: begin
          if (used == 0) r.status = ale_pkg::ST_EMPTY;
          else begin
            // first match wins
            for (int unsigned i = 0; i < used; i++) begin
              if (slots[i] == w.item_id) begin
                r.result_id = slots[i];
                r.found = 1'b1;
                break;
              end
            end
          end
        end
        ale_pkg::OP_INDEX_OF: begin
          if (used == 0) r.status = ale_pkg::ST_EMPTY;
          else begin
            // last match wins
            for (int unsigned i = 0; i < used; i++) begin
              if (slots[i] == w.item_id) begin
                r.match_index = ale_pkg::MIDX_W'(i);
                r.found = 1'b1;
              end
            end
          end
        end
        ale_pkg::OP_CLEAR: used = 0;
        default: ;
      endcase
      r.entry_count = ale_pkg::COUNT_W'(used);
      if (r.found) search_hits++;
      if (used > peak_fill) peak_fill = used;
      status_tally[r.status]++;
      words_in++;
      pending_q.push_back(r);
    endfunction

    task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
      mismatches++;
      $display("%0t MISMATCH word %0d %s: got %0h want %0h",
               $realtime, words_out, what, got_v, want_v);
    endtask

    task check_word(ale_pkg::ale_out_t got);
      ale_pkg::ale_out_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.result_id != want.result_id)
        report_mismatch("result_id", got.result_id, want.result_id);
      if (got.found != want.found) report_mismatch("found", got.found, want.found);
      if (got.match_index != want.match_index)
        report_mismatch("match_index", got.match_index, want.match_index);
      if (got.entry_count != want.entry_count)
        report_mismatch("entry_count", got.entry_count, want.entry_count);
      words_out++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ale_pkg::ale_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ale_pkg::ale_out_t out_data;

  list_scoreboard sb;

  int unsigned  hold_asks = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  mode_left = 0;
  int unsigned  cyc = 0;
  stall_style_t stall_mode = STALL_NONE;

  array_list_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern; a requested hold-off takes priority
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_style_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(10, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
        default:     out_stall <= (cyc % 9) < 4;
      endcase
    end
  end

  // Check every result word taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
  end

  // Hold one command word until the block takes it, then log it
  task send_word(ale_pkg::ale_in_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task send_op(logic [ale_pkg::CMD_W-1:0] op, int unsigned pos,
               logic [ale_pkg::IDF_W-1:0] id);
    ale_pkg::ale_in_t w;
    w.command  = op;
    w.position = ale_pkg::POS_W'(pos);
    w.item_id  = id;
    send_word(w);
  endtask

  task idle_input(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= ale_pkg::ale_in_t'($urandom);
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task drain_results();
    idle_input(1);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Build a random command, steered toward growing, shrinking or mixed use
  function ale_pkg::ale_in_t make_word(mix_t mix);
    ale_pkg::ale_in_t w;
    int unsigned      n, r, ins_w, rem_w;
    n = sb.used;
    case (mix)
      MIX_GROW:   begin ins_w = 80; rem_w = 5;  end
      MIX_SHRINK: begin ins_w = 10; rem_w = 60; end
      default:    begin ins_w = 30; rem_w = 30; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_w) begin
      case ($urandom_range(0, 2))
        0:       w.command = ale_pkg::OP_INS_FRONT;
        1:       w.command = ale_pkg::OP_INS_BACK;
        default: w.command = ale_pkg::OP_INS_AT;
      endcase
    end else if (r < ins_w + rem_w) begin
      case ($urandom_range(0, 2))
        0:       w.command = ale_pkg::OP_REM_FRONT;
        1:       w.command = ale_pkg::OP_REM_BACK;
        default: w.command = ale_pkg::OP_REM_AT;
      endcase
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25)      w.command = ale_pkg::OP_GET;
      else if (r < 45) w.command = ale_pkg::OP_SET;
      else if (r < 70) w.command = ale_pkg::OP_FIND;
      else if (r < 93) w.command = ale_pkg::OP_INDEX_OF;
      else if (r < 96 && mix != MIX_GROW) w.command = ale_pkg::OP_CLEAR;
      else w.command = ale_pkg::CMD_W'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
    end
    // mostly legal positions, some at the edges, some anywhere
    r = $urandom_range(0, 19);
    if (r < 16 && n > 0) w.position = ale_pkg::POS_W'($urandom_range(1, n));
    else if (r < 18) begin
      case ($urandom_range(0, 2))
        0:       w.position = '0;
        1:       w.position = ale_pkg::POS_W'(n);
        default: w.position = ale_pkg::POS_W'(n + 1);
      endcase
    end else w.position = ale_pkg::POS_W'($urandom_range(0, 127));
    // reuse stored ids often so searches hit
    r = $urandom_range(0, 9);
    if (r < 5 && n > 0) w.item_id = sb.slots[$urandom_range(0, n - 1)];
    else if (r < 7) w.item_id = ale_pkg::IDF_W'($urandom_range(0, 7));
    else w.item_id = ale_pkg::IDF_W'($urandom);
    return w;
  endfunction

  // Main stimulus
  initial begin
    int unsigned sent;
    int unsigned burst_left;
    int unsigned seg_left;
    mix_t        mix;
    bit          no_gaps;
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // empty list: bad-position and empty errors, an unused command and a clear
    send_op(ale_pkg::OP_GET,       1, 16'h0001);
    send_op(ale_pkg::OP_SET,       1, 16'h0002);
    send_op(ale_pkg::OP_REM_FRONT, 0, 16'h0000);
    send_op(ale_pkg::OP_REM_BACK,  0, 16'h0000);
    send_op(ale_pkg::OP_REM_AT,    0, 16'h0000);
    send_op(ale_pkg::OP_FIND,      0, 16'h0000);
    send_op(ale_pkg::OP_INDEX_OF,  0, 16'h0000);
    send_op(ale_pkg::OP_INS_AT,    1, 16'h5555);
    send_op(LAST_UNUSED_OP, 7'h7F, 16'hFFFF);
    send_op(ale_pkg::OP_CLEAR,     0, 16'h0000);
    // build a short list with extreme ids
    send_op(ale_pkg::OP_INS_BACK,  0, 16'hFFFF);
    send_op(ale_pkg::OP_INS_FRONT, 0, 16'h0000);
    send_op(ale_pkg::OP_INS_AT,    2, 16'h8001);
    send_op(ale_pkg::OP_INS_AT,    3, 16'h7FFE);
    send_op(ale_pkg::OP_SET,       4, 16'h8001);
    send_op(ale_pkg::OP_GET,       4, 16'h0000);
    send_op(ale_pkg::OP_GET,       5, 16'h0000);
    send_op(ale_pkg::OP_GET,       7'h7F, 16'h0000);
    // searches: hit with duplicates, then a miss
    send_op(ale_pkg::OP_FIND,      0, 16'h8001);
    send_op(ale_pkg::OP_INDEX_OF,  0, 16'h8001);
    send_op(ale_pkg::OP_FIND,      0, 16'h1234);
    send_op(ale_pkg::OP_INDEX_OF,  0, 16'h1234);
    send_op(ale_pkg::OP_REM_AT,    2, 16'h0000);
    send_op(ale_pkg::OP_REM_FRONT, 0, 16'h0000);
    send_op(ale_pkg::OP_REM_BACK,  0, 16'h0000);
    send_op(FIRST_UNUSED_OP, 0, 16'h0000);
    send_op(ale_pkg::OP_CLEAR,     0, 16'h0000);
    drain_results();

    // random part, first segment fills the list
    sent = 0;
    burst_left = 0;
    seg_left = 100;
    mix = MIX_GROW;
    no_gaps = 1'b0;
    while (sent < RANDOM_WORDS) begin
      if (seg_left == 0) begin
        mix      = mix_t'($urandom_range(0, 2));
        seg_left = $urandom_range(30, 120);
        no_gaps  = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) drain_results();
      end
      if (sent == RANDOM_WORDS / 4) hold_asks++;
      if (sent == RANDOM_WORDS / 2) drain_results();
      send_word(make_word(mix));
      sent++;
      seg_left--;
      if (!no_gaps) begin
        if (burst_left == 0) begin
          idle_input($urandom_range(1, 15));
          burst_left = $urandom_range(1, 25);
        end else begin
          burst_left--;
        end
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d commands, %0d results; list peaked at %0d of %0d entries.",
             sb.words_in, sb.words_out, sb.peak_fill, LIST_DEPTH);
    $display("Status ok/full/empty/badpos: %0d/%0d/%0d/%0d, search hits %0d.",
             sb.status_tally[ale_pkg::ST_OK], sb.status_tally[ale_pkg::ST_FULL],
             sb.status_tally[ale_pkg::ST_EMPTY], sb.status_tally[ale_pkg::ST_BADPOS],
             sb.search_hits);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d results still outstanding.", sb.pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
